// ===== sv/assert_macros.svh =====
// Assertion macros included by base64_stream_decoder_top.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed: label");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed: label");

`endif

// ===== sv/b64dec_pkg.sv =====
// Types, constants and decode functions of the base64 stream decoder.
package b64dec_pkg;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic REG_REMAP = 1'b0;    // register index of remap_enable

    localparam int QDEPTH   = 4;          // result queue depth, power of two
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = QPTR_W + 1;
    localparam int MAX_RES  = 3;          // results one item may cause

    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_TWO   = 8'h32;
    localparam logic [7:0] CH_LOWA  = 8'h61;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       final_res;
        logic       last_in_run;
    } res_t;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } sextet_t;

    // Rotate 2->1, a->2, 1->a when enabled.
    function automatic logic [7:0] remap_char(input logic [7:0] ch, input logic en);
        logic [7:0] r;
        r = ch;
        if (en) begin
            if (ch == CH_TWO)       r = CH_ONE;
            else if (ch == CH_LOWA) r = CH_TWO;
            else if (ch == CH_ONE)  r = CH_LOWA;
        end
        return r;
    endfunction

    function automatic sextet_t sextet_of(input logic [7:0] ch);
        sextet_t s;
        s.ok    = 1'b1;
        s.value = 6'd0;
        if (ch inside {[8'h41:8'h5a]})      s.value = 6'(ch - 8'h41);
        else if (ch inside {[8'h61:8'h7a]}) s.value = 6'(ch - 8'h61 + 8'd26);
        else if (ch inside {[8'h30:8'h39]}) s.value = 6'(ch - 8'h30 + 8'd52);
        else if (ch == CH_PLUS)             s.value = 6'd62;
        else if (ch == CH_SLASH)            s.value = 6'd63;
        else                                s.ok    = 1'b0;
        return s;
    endfunction

endpackage

// ===== sv/base64_stream_decoder_top.sv =====
// Base64 stream decoder: input register, one-pass decode, result queue.
//
//  channel | dir | ports                                            | moves
//  s_      | in  | s_valid s_ready s_op s_text_char                 | one character or end
//  m_      | out | m_valid m_ready m_data_byte m_has_byte           | one result
//          |     | m_final_res m_last_in_run                        |
//  apb     | in  | psel penable pwrite paddr pwdata prdata pready   | remap_enable at 0x0
//
// An item is taken into the input register, decoded from that register and its
// zero to three results written at once into a four-entry result queue.
// Results leave one per cycle while m_ready is high; a new character can be taken
// while the last one is decoded, and a completed group of four gives three results.
// The input register waits while the queue lacks room for all results of its item.
// Reset (aresetn low, synchronous) empties both and clears count and stop flag.
`include "assert_macros.svh"

module base64_stream_decoder_top
    import b64dec_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_text_char,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_data_byte,
    output logic        m_has_byte,
    output logic        m_final_res,
    output logic        m_last_in_run,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic              remap_reg;
    logic              in_valid_reg;
    logic              in_op_reg;
    logic [7:0]        in_char_reg;
    logic [5:0]        sext_reg [MAX_RES];
    logic [1:0]        sext_count_reg, sext_count_next;
    logic              stopped_reg, stopped_next;
    res_t              q_reg [QDEPTH];
    logic [QPTR_W-1:0] q_wr_reg, q_rd_reg;
    logic [QCNT_W-1:0] q_count_reg;

    logic              proc;
    logic              s_accept;
    logic              m_accept;
    logic [7:0]        ch;
    sextet_t           sx;
    logic [7:0]        bytes [MAX_RES];
    logic [1:0]        flush_n;
    logic [1:0]        n_bytes;
    logic              emit_final;
    logic [1:0]        push_n;
    logic              buf_write;
    res_t              res [MAX_RES];
    logic [QPTR_W-1:0] wr_idx [MAX_RES];

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REMAP) ? {31'd0, remap_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remap_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_REMAP) begin
            remap_reg <= pwdata[0];
        end
    end

    // ---------------- input register ----------------
    // advance only when every result of the held item fits in the queue
    assign proc     = in_valid_reg &&
                      ((q_count_reg + QCNT_W'(push_n)) <= QCNT_W'(QDEPTH));
    assign s_ready  = !in_valid_reg || proc;
    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg   <= s_op;
            in_char_reg <= s_text_char;
        end
    end

    // ---------------- decode ----------------
    assign ch = remap_char(in_char_reg, remap_reg);
    assign sx = sextet_of(ch);

    assign bytes[0] = {sext_reg[0], sext_reg[1][5:4]};
    assign bytes[1] = {sext_reg[1][3:0], sext_reg[2][5:2]};
    assign bytes[2] = {sext_reg[2][1:0], sx.value};

    // partial group of n sextets flushes n-1 bytes
    assign flush_n = (sext_count_reg == 2'd3) ? 2'd2 :
                     (sext_count_reg == 2'd2) ? 2'd1 : 2'd0;

    always_comb begin
        n_bytes         = 2'd0;
        emit_final      = 1'b0;
        buf_write       = 1'b0;
        sext_count_next = sext_count_reg;
        stopped_next    = stopped_reg;
        if (in_op_reg == OP_END) begin
            n_bytes         = stopped_reg ? 2'd0 : flush_n;
            emit_final      = 1'b1;
            sext_count_next = 2'd0;
            stopped_next    = 1'b0;
        end else if (!stopped_reg) begin
            if (!sx.ok) begin
                n_bytes         = flush_n;
                sext_count_next = 2'd0;
                stopped_next    = 1'b1;
            end else if (sext_count_reg != 2'd3) begin
                buf_write       = 1'b1;
                sext_count_next = sext_count_reg + 2'd1;
            end else begin
                n_bytes         = 2'd3;
                sext_count_next = 2'd0;
            end
        end
        push_n = n_bytes + {1'b0, emit_final};
    end

    always_comb begin
        for (int k = 0; k < MAX_RES; k++) begin
            wr_idx[k] = q_wr_reg + QPTR_W'(k);
            if (2'(k) < n_bytes) begin
                res[k].data_byte = bytes[k];
                res[k].has_byte  = 1'b1;
                res[k].final_res = 1'b0;
            end else begin
                res[k].data_byte = 8'd0;
                res[k].has_byte  = 1'b0;
                res[k].final_res = 1'b1;
            end
            res[k].last_in_run = (2'(k) == push_n - 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sext_count_reg <= 2'd0;
            stopped_reg    <= 1'b0;
        end else if (proc) begin
            sext_count_reg <= sext_count_next;
            stopped_reg    <= stopped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && buf_write) begin
            sext_reg[sext_count_reg] <= sx.value;
        end
    end

    // ---------------- result queue ----------------
    assign m_valid       = (q_count_reg != '0);
    assign m_accept      = m_valid && m_ready;
    assign m_data_byte   = q_reg[q_rd_reg].data_byte;
    assign m_has_byte    = q_reg[q_rd_reg].has_byte;
    assign m_final_res   = q_reg[q_rd_reg].final_res;
    assign m_last_in_run = q_reg[q_rd_reg].last_in_run;

    always_ff @(posedge aclk) begin
        if (proc) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (2'(k) < push_n) begin
                    q_reg[wr_idx[k]] <= res[k];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_wr_reg    <= '0;
            q_rd_reg    <= '0;
            q_count_reg <= '0;
        end else begin
            if (proc) begin
                q_wr_reg <= q_wr_reg + QPTR_W'(push_n);
            end
            if (m_accept) begin
                q_rd_reg <= q_rd_reg + QPTR_W'(1);
            end
            q_count_reg <= q_count_reg + (proc ? QCNT_W'(push_n) : QCNT_W'(0))
                           - QCNT_W'(m_accept);
        end
    end

    // ---------------- assertions ----------------
    `ASSERT_SAME(a_queue_bound, aclk, aresetn, 1'b1, q_count_reg <= QCNT_W'(QDEPTH))
    `ASSERT_SAME(a_stopped_silent, aclk, aresetn,
                 proc && stopped_reg && in_op_reg == OP_CHAR, push_n == 2'd0)
    `ASSERT_NEXT(a_end_clears, aclk, aresetn, proc && in_op_reg == OP_END,
                 sext_count_reg == 2'd0 && !stopped_reg)
    `ASSERT_NEXT(a_push_visible, aclk, aresetn, proc && push_n != 2'd0, m_valid)

endmodule
